// ----- src/spa_pkg.sv -----
// shared types, codes and defaults of the slot pool allocator
`timescale 1ns / 1ps
`default_nettype none
package spa_pkg;

  localparam int SPA_SLOTS = 1024;

  localparam int SLOT_W  = 10;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_FREED   = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_FIX   = 4'b0100,
    S_CLR   = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// ----- src/slot_pool_allocator_core.sv -----
// slot pool allocator: free-slot stack, dense live list and per-kind counts
//
// input words carry an op in in_tuser and kind, slot and position in in_tdata.
// every input word yields exactly one output word with a status in out_tuser
// and the slot, its kind and the pool counts after the op in out_tdata.
// allocate, clear and any rejected op load the output register from the
// fetch state, a successful release or read from the fix state after it:
// each needs one or two dependent reads of the synchronous pool ram (free
// stack below the free count, dense list mirrored from the top) and of the
// slot ram (kind and dense position per slot). the word is offered from the
// next cycle on and the next input word is accepted in the cycle after the
// load, even while the last word still waits for the receiver.
// a clear op loads its result and then rewrites both rams, one entry a
// cycle, through every slot before the next word is accepted.
// after reset the same pass runs with in_tready low.
// a stalled receiver holds the result in the output register; the block
// still takes the next input word and holds it just before its own result
// until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module slot_pool_allocator_core
  import spa_pkg::*;
#(
  parameter int SLOTS = SPA_SLOTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // kind[1:0], slot[11:2], position[21:12], zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // op[1:0]
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // slot_out[9:0], kind_out[11:10], free_count[22:12], live_count[33:23],
  // kind1_count[44:34], kind2_count[55:45], kind3_count[66:56], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [1:0]                 out_tuser
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] TOP_ADDR = AW'(SLOTS - 1);

  function automatic logic [COUNT_W-1:0] cnt_out(input logic [CW-1:0] c);
    logic [CW+COUNT_W-1:0] e;
    e = {{COUNT_W{1'b0}}, c};
    return e[COUNT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_out(input logic [AW-1:0] s);
    logic [AW+SLOT_W-1:0] e;
    e = {{SLOT_W{1'b0}}, s};
    return e[SLOT_W-1:0];
  endfunction

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]       sel_r, sel_nxt;
  logic [AW-1:0]       dpos_r, dpos_nxt;
  logic [KIND_W-1:0]   skind_r, skind_nxt;
  logic [AW-1:0]       clr_idx_r, clr_idx_nxt;
  logic [CW-1:0]       free_r, free_nxt;
  logic [CW-1:0]       live_r, live_nxt;
  logic [CW-1:0]       kcnt_r [3];
  logic [CW-1:0]       kcnt_nxt [3];
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]          out_user_r;

  logic                pw_en, pr_en, sw_en, sr_en;
  logic [AW-1:0]       pw_addr, pr_addr, sw_addr, sr_addr;
  logic [AW-1:0]       pw_data, p_rdata;
  logic [AW+1:0]       sw_data, s_rdata;
  logic [KIND_W-1:0]   s_kind;
  logic [AW-1:0]       s_pos;

  logic                res_fire;
  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [KIND_W-1:0]   res_kind;
  logic                out_free;
  logic                accept;
  logic                rel_ok, pos_ok;
  logic [1:0]          kidx;

  assign s_kind = s_rdata[AW+1:AW];
  assign s_pos  = s_rdata[AW-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign rel_ok = (32'(slot_r) < SLOTS) && (s_kind != 2'd0) && (live_r != '0);
  assign pos_ok = 32'(pos_r) < 32'(live_r);

  spa_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_pool_ram (
    .clk     (clk),
    .wr_en   (pw_en),
    .wr_addr (pw_addr),
    .wr_data (pw_data),
    .rd_en   (pr_en),
    .rd_addr (pr_addr),
    .rd_data (p_rdata)
  );

  spa_ram #(.WIDTH(AW + 2), .DEPTH(SLOTS)) u_slot_ram (
    .clk     (clk),
    .wr_en   (sw_en),
    .wr_addr (sw_addr),
    .wr_data (sw_data),
    .rd_en   (sr_en),
    .rd_addr (sr_addr),
    .rd_data (s_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    kind_nxt    = kind_r;
    slot_nxt    = slot_r;
    pos_nxt     = pos_r;
    sel_nxt     = sel_r;
    dpos_nxt    = dpos_r;
    skind_nxt   = skind_r;
    clr_idx_nxt = clr_idx_r;
    free_nxt    = free_r;
    live_nxt    = live_r;
    kcnt_nxt    = kcnt_r;
    pw_en       = 1'b0;
    pw_addr     = '0;
    pw_data     = '0;
    pr_en       = 1'b0;
    pr_addr     = '0;
    sw_en       = 1'b0;
    sw_addr     = '0;
    sw_data     = '0;
    sr_en       = 1'b0;
    sr_addr     = '0;
    res_fire    = 1'b0;
    res_status  = ST_OK;
    res_slot    = '0;
    res_kind    = '0;
    kidx        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = op_t'(in_tuser);
          kind_nxt = in_tdata[1:0];
          slot_nxt = in_tdata[11:2];
          pos_nxt  = in_tdata[21:12];
          pr_en    = 1'b1;
          sr_en    = 1'b1;
          sr_addr  = AW'(in_tdata[11:2]);
          unique case (op_t'(in_tuser))
            OP_ALLOC:   pr_addr = AW'(free_r - CW'(1));
            OP_RELEASE: pr_addr = AW'(free_r);
            OP_READ:    pr_addr = TOP_ADDR - AW'(in_tdata[21:12]);
            OP_CLEAR:   pr_addr = '0;
          endcase
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        unique case (op_r)
          OP_ALLOC: begin
            if (out_free) begin
              res_fire  = 1'b1;
              state_nxt = S_IDLE;
              if (kind_r == 2'd0) begin
                res_status = ST_RANGE;
              end else if (free_r == '0) begin
                res_status = ST_FULL;
              end else begin
                kidx     = kind_r - 2'd1;
                sw_en    = 1'b1;
                sw_addr  = p_rdata;
                sw_data  = {kind_r, AW'(live_r)};
                free_nxt = free_r - CW'(1);
                live_nxt = live_r + CW'(1);
                kcnt_nxt[kidx] = kcnt_r[kidx] + CW'(1);
                res_slot = slot_out(p_rdata);
                res_kind = kind_r;
              end
            end
          end
          OP_RELEASE: begin
            if (rel_ok) begin
              pw_en     = 1'b1;
              pw_addr   = AW'(free_r);
              pw_data   = AW'(slot_r);
              sw_en     = 1'b1;
              sw_addr   = AW'(slot_r);
              sw_data   = {2'd0, s_pos};
              sel_nxt   = p_rdata;
              dpos_nxt  = s_pos;
              skind_nxt = s_kind;
              sr_en     = 1'b1;
              sr_addr   = p_rdata;
              state_nxt = S_FIX;
            end else if (out_free) begin
              res_fire   = 1'b1;
              res_status = ST_FREED;
              res_slot   = slot_r;
              state_nxt  = S_IDLE;
            end
          end
          OP_READ: begin
            if (pos_ok) begin
              sel_nxt   = p_rdata;
              sr_en     = 1'b1;
              sr_addr   = p_rdata;
              state_nxt = S_FIX;
            end else if (out_free) begin
              res_fire   = 1'b1;
              res_status = ST_RANGE;
              state_nxt  = S_IDLE;
            end
          end
          OP_CLEAR: begin
            if (out_free) begin
              res_fire    = 1'b1;
              free_nxt    = CW'(SLOTS);
              live_nxt    = '0;
              kcnt_nxt[0] = '0;
              kcnt_nxt[1] = '0;
              kcnt_nxt[2] = '0;
              clr_idx_nxt = '0;
              state_nxt   = S_CLR;
            end
          end
        endcase
      end
      S_FIX: begin
        if (out_free) begin
          res_fire  = 1'b1;
          state_nxt = S_IDLE;
          if (op_r == OP_RELEASE) begin
            kidx    = skind_r - 2'd1;
            pw_en   = 1'b1;
            pw_addr = TOP_ADDR - dpos_r;
            pw_data = sel_r;
            if (sel_r != AW'(slot_r)) begin
              sw_en   = 1'b1;
              sw_addr = sel_r;
              sw_data = {s_kind, dpos_r};
            end
            free_nxt = free_r + CW'(1);
            live_nxt = live_r - CW'(1);
            kcnt_nxt[kidx] = kcnt_r[kidx] - CW'(1);
            res_slot = slot_r;
            res_kind = skind_r;
          end else begin
            res_slot = slot_out(sel_r);
            res_kind = s_kind;
          end
        end
      end
      S_CLR: begin
        pw_en   = 1'b1;
        pw_addr = clr_idx_r;
        pw_data = TOP_ADDR - clr_idx_r;
        sw_en   = 1'b1;
        sw_addr = clr_idx_r;
        sw_data = '0;
        if (clr_idx_r == TOP_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      free_r      <= CW'(SLOTS);
      live_r      <= '0;
      kcnt_r[0]   <= '0;
      kcnt_r[1]   <= '0;
      kcnt_r[2]   <= '0;
      out_valid_r <= 1'b0;
      op_r        <= OP_ALLOC;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      free_r      <= free_nxt;
      live_r      <= live_nxt;
      kcnt_r      <= kcnt_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    slot_r  <= slot_nxt;
    pos_r   <= pos_nxt;
    sel_r   <= sel_nxt;
    dpos_r  <= dpos_nxt;
    skind_r <= skind_nxt;
    if (res_fire) begin
      out_user_r <= res_status;
      out_data_r <= {5'd0,
                     cnt_out(kcnt_nxt[2]), cnt_out(kcnt_nxt[1]), cnt_out(kcnt_nxt[0]),
                     cnt_out(live_nxt), cnt_out(free_nxt), res_kind, res_slot};
    end
  end

endmodule
`default_nettype wire

// ----- src/spa_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
